// File: design/fpalu_pkg.sv
// shared types, constants and opcodes of the q24.8 fixed-point alu
`default_nettype none
package fpalu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
    localparam int OP_BITS   = 4;
    localparam int IN_FIELDS  = OP_BITS + 2 * WORD_BITS;
    localparam int IN_BITS    = ((IN_FIELDS + 7) / 8) * 8;
    localparam int OUT_FIELDS = WORD_BITS + 4;
    localparam int OUT_BITS   = ((OUT_FIELDS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } t_op;

    // everything that rides alongside the divider
    typedef struct packed {
        logic                 is_div;
        logic                 is_mul;
        logic                 neg;
        logic                 dz;
        logic                 a_less;
        logic                 a_equal;
        logic                 a_greater;
        logic [WORD_BITS-1:0] mag_b;
        logic [WORD_BITS-1:0] prod_mid;
        logic [WORD_BITS-1:0] simple;
    } t_payload;

    // partial remainder and shifting dividend / quotient word
    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [DIV_BITS-1:0]  dq;
    } t_div;

endpackage
`default_nettype wire

// File: design/fpalu_prep.sv
// front stage: decode, compare, simple ops, magnitudes and the product
`default_nettype none
module fpalu_prep
    import fpalu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [OP_BITS-1:0]   i_op,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    output logic                      o_valid,
    output t_payload                  o_pay,
    output t_div                      o_div
);

    logic signed [WORD_BITS-1:0] a_s;
    logic signed [WORD_BITS-1:0] b_s;
    logic [WORD_BITS-1:0]        mag_a;
    logic [WORD_BITS-1:0]        mag_b;
    logic [2*WORD_BITS-1:0]      prod;
    logic                        lt;
    logic                        gt;
    logic [WORD_BITS-1:0]        simple;
    logic                        r_valid;
    t_payload                    r_pay;
    t_div                        r_div;

    assign a_s   = $signed(i_a);
    assign b_s   = $signed(i_b);
    assign lt    = a_s < b_s;
    assign gt    = a_s > b_s;
    assign mag_a = i_a[WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[WORD_BITS-1] ? (~i_b + 1'b1) : i_b;
    assign prod  = mag_a * mag_b;

    // results that need no multiplier or divider
    always_comb begin
        case (i_op)
            OP_ADD:      simple = i_a + i_b;
            OP_SUB:      simple = i_a - i_b;
            OP_MIN:      simple = lt ? i_a : i_b;
            OP_MAX:      simple = gt ? i_a : i_b;
            OP_INC:      simple = i_a + 1'b1;
            OP_DEC:      simple = i_a - 1'b1;
            OP_FROM_INT: simple = i_a << FRAC_BITS;
            OP_TO_INT:   simple = $unsigned(a_s >>> FRAC_BITS);
            default:     simple = '0;
        endcase
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload and divider seed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay.is_div    <= (i_op == OP_DIV);
            r_pay.is_mul    <= (i_op == OP_MUL);
            r_pay.neg       <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
            r_pay.dz        <= (i_op == OP_DIV) && (i_b == '0);
            r_pay.a_less    <= lt;
            r_pay.a_equal   <= (i_a == i_b);
            r_pay.a_greater <= gt;
            r_pay.mag_b     <= mag_b;
            r_pay.prod_mid  <= prod[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
            r_pay.simple    <= simple;
            r_div.rem       <= '0;
            r_div.dq        <= {mag_a, {FRAC_BITS{1'b0}}};
        end
    end

    assign o_valid = r_valid;
    assign o_pay   = r_pay;
    assign o_div   = r_div;

endmodule
`default_nettype wire

// File: design/fpalu_cell.sv
// one divider cell: one restoring quotient bit per item, plus payload hand-on
`default_nettype none
module fpalu_cell
    import fpalu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire t_payload i_pay,
    input  wire t_div     i_div,
    output logic          o_valid,
    output t_payload      o_pay,
    output t_div          o_div
);

    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 qbit;
    logic [WORD_BITS-1:0] n_rem;
    logic                 r_valid;
    t_payload             r_pay;
    t_div                 r_div;

    // shift in the next dividend bit and try the subtract
    assign trial = {i_div.rem, i_div.dq[DIV_BITS-1]};
    assign diff  = trial - {1'b0, i_pay.mag_b};
    assign qbit  = ~diff[WORD_BITS];
    assign n_rem = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // state handed to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay     <= i_pay;
            r_div.rem <= n_rem;
            r_div.dq  <= {i_div.dq[DIV_BITS-2:0], qbit};
        end
    end

    assign o_valid = r_valid;
    assign o_pay   = r_pay;
    assign o_div   = r_div;

endmodule
`default_nettype wire

// File: design/fpalu_post.sv
// output stage: sign fix-up, result select and output register
`default_nettype none
module fpalu_post
    import fpalu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire t_payload           i_pay,
    input  wire t_div               i_div,
    output logic                    o_valid,
    output logic [OUT_BITS-1:0]     o_data
);

    logic [WORD_BITS-1:0] quot;
    logic [WORD_BITS-1:0] res;
    logic                 r_valid;
    logic [OUT_BITS-1:0]  r_data;

    assign quot = i_div.dq[WORD_BITS-1:0];

    // pick the result for the operation
    always_comb begin
        if (i_pay.dz) begin
            res = '0;
        end else if (i_pay.is_div) begin
            res = i_pay.neg ? (~quot + 1'b1) : quot;
        end else if (i_pay.is_mul) begin
            res = i_pay.neg ? (~i_pay.prod_mid + 1'b1) : i_pay.prod_mid;
        end else begin
            res = i_pay.simple;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // packed result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= {{(OUT_BITS-OUT_FIELDS){1'b0}}, i_pay.dz, i_pay.a_greater,
                       i_pay.a_equal, i_pay.a_less, res};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

// File: design/fixed_point_q24_8_alu_unit.sv
// top level of the q24.8 fixed-point alu
`default_nettype none
// Signed 32-bit fixed-point alu with 8 fractional bits. It accepts one request
// per clock while the output is not held, and returns one result per request in
// order, through one front stage (compare, simple ops, 32x32 magnitude multiply),
// a chain of 40 divider cells that each settle one quotient bit, and one output
// register. All operations go through the same chain.
// The whole chain advances whenever the output register is empty or taken.
module fixed_point_q24_8_alu_unit
    import fpalu_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // op[3:0], operand_a[35:4], operand_b[67:36], zero pad
    input  wire logic [IN_BITS-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // result[31:0], a_less[32], a_equal[33], a_greater[34], divide_by_zero[35], pad
    output logic [OUT_BITS-1:0]      o_m_axis_tdata
);

    logic     en;
    logic     w_valid [DIV_BITS+1];
    t_payload w_pay   [DIV_BITS+1];
    t_div     w_div   [DIV_BITS+1];

    // chain advances unless the output is held
    assign en              = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = en;

    fpalu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_op    (i_s_axis_tdata[OP_BITS-1:0]),
        .i_a     (i_s_axis_tdata[OP_BITS+WORD_BITS-1:OP_BITS]),
        .i_b     (i_s_axis_tdata[OP_BITS+2*WORD_BITS-1:OP_BITS+WORD_BITS]),
        .o_valid (w_valid[0]),
        .o_pay   (w_pay[0]),
        .o_div   (w_div[0])
    );

    // divider cell chain
    for (genvar g = 0; g < DIV_BITS; g++) begin : g_cell
        fpalu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_pay   (w_pay[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_pay   (w_pay[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    fpalu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid[DIV_BITS]),
        .i_pay   (w_pay[DIV_BITS]),
        .i_div   (w_div[DIV_BITS]),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

`ifndef SYNTHESIS
    // exactly one compare flag on every result
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot(o_m_axis_tdata[WORD_BITS+2:WORD_BITS]))
        else $error("compare flags not one-hot");

    // divide by zero gives a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[WORD_BITS+3])
        |-> (o_m_axis_tdata[WORD_BITS-1:0] == '0))
        else $error("divide by zero with non-zero result");

    // output empty straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid straight after reset");
`endif

endmodule
`default_nettype wire
